// ===== sv/tksi_pkg.sv =====
// ----------------------------------------------------------------------------
// tksi_pkg
// Shared widths, request codes and controller/datapath interface structs
// for the top-K sorted insertion table.
// ----------------------------------------------------------------------------
package tksi_pkg;

    localparam int SCORE_W = 31;
    localparam int LEVEL_W = 16;
    localparam int RANK_W  = 3;
    localparam int IDX_W   = 3;

    typedef logic [SCORE_W-1:0] score_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [RANK_W-1:0]  rank_t;
    typedef logic [IDX_W-1:0]   idx_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the incoming word, clear the result
        logic step;       // move the cursor one place toward the top
        logic shift_wr;   // copy the entry under the cursor one place down
        logic put_above;  // write the new record just below the cursor
        logic put_here;   // write the new record at the cursor
        logic capture_rd; // take the entry under the cursor as read result
        logic publish;    // copy the result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic beats;      // new record strictly beats entry under cursor
        logic at_top;     // cursor at position 0
        logic at_bottom;  // cursor at the last position
    } status_t;

endpackage

// ===== sv/tksi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tksi_ctrl
// Sequencer for the sorted table: bottom-up probe and shift for inserts,
// single lookup for reads, and the output-register handshake.
// ----------------------------------------------------------------------------
module tksi_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    output logic               m_valid,
    input  logic               m_ready,
    input  tksi_pkg::status_t  status,
    output tksi_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_req_type == tksi_pkg::REQ_READ) ? S_READ : S_PROBE;
                end
            end
            S_PROBE: begin
                if (status.beats) begin
                    cmd.shift_wr = !status.at_bottom;
                    if (status.at_top) begin
                        state_next = S_PLACE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end else begin
                    // entry under the cursor holds: place below it, drop at the bottom
                    cmd.put_above = !status.at_bottom;
                    state_next    = S_DONE;
                end
            end
            S_PLACE: begin
                cmd.put_here = 1'b1;
                state_next   = S_DONE;
            end
            S_READ: begin
                cmd.capture_rd = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.publish) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/tksi_dp.sv =====
// ----------------------------------------------------------------------------
// tksi_dp
// Datapath: table memory with per-entry valid bits, scan cursor, key
// compare, result holding register and output register.
// ----------------------------------------------------------------------------
module tksi_dp #(
    parameter int ENTRIES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tksi_pkg::score_t    s_new_score,
    input  tksi_pkg::level_t    s_new_level,
    input  tksi_pkg::idx_t      s_read_index,
    input  logic                s_req_type,
    input  tksi_pkg::cmd_t      cmd,
    output tksi_pkg::status_t   status,
    output logic                m_placed,
    output tksi_pkg::rank_t     m_rank,
    output tksi_pkg::score_t    m_entry_score,
    output tksi_pkg::level_t    m_entry_level
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    typedef logic [IW-1:0] pos_t;

    localparam pos_t LAST_POS = pos_t'(ENTRIES - 1);

    tksi_pkg::score_t mem_score [ENTRIES];
    tksi_pkg::level_t mem_level [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;

    tksi_pkg::score_t rd_score_reg;
    tksi_pkg::level_t rd_level_reg;
    logic             rd_vld_reg;

    pos_t             cur_reg, cur_next;
    tksi_pkg::score_t new_score_reg;
    tksi_pkg::level_t new_level_reg;
    logic             idx_ok_reg;

    logic             res_placed_reg;
    tksi_pkg::rank_t  res_rank_reg;
    tksi_pkg::score_t res_score_reg;
    tksi_pkg::level_t res_level_reg;

    logic             m_placed_reg;
    tksi_pkg::rank_t  m_rank_reg;
    tksi_pkg::score_t m_score_reg;
    tksi_pkg::level_t m_level_reg;

    tksi_pkg::score_t ent_score;
    tksi_pkg::level_t ent_level;
    pos_t             cur_below;
    logic             we;
    pos_t             waddr;
    tksi_pkg::score_t wscore;
    tksi_pkg::level_t wlevel;

    // an entry never written reads as the reset value, zero
    assign ent_score = rd_vld_reg ? rd_score_reg : '0;
    assign ent_level = rd_vld_reg ? rd_level_reg : '0;
    assign cur_below = cur_reg + pos_t'(1);

    assign status.beats = (new_score_reg > ent_score) ||
                          ((new_score_reg == ent_score) && (new_level_reg > ent_level));
    assign status.at_top    = (cur_reg == '0);
    assign status.at_bottom = (cur_reg == LAST_POS);

    always_comb begin
        cur_next = cur_reg;
        if (cmd.load) begin
            cur_next = (s_req_type == tksi_pkg::REQ_READ) ? pos_t'(s_read_index) : LAST_POS;
        end else if (cmd.step) begin
            cur_next = cur_reg - pos_t'(1);
        end
    end

    assign we     = cmd.shift_wr || cmd.put_above || cmd.put_here;
    assign waddr  = cmd.put_here ? cur_reg : cur_below;
    assign wscore = cmd.shift_wr ? ent_score : new_score_reg;
    assign wlevel = cmd.shift_wr ? ent_level : new_level_reg;

    // table memory; read address follows the cursor so read data lines up
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_score[waddr] <= wscore;
            mem_level[waddr] <= wlevel;
        end
        rd_score_reg <= mem_score[cur_next];
        rd_level_reg <= mem_level[cur_next];
        rd_vld_reg   <= vld_reg[cur_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            new_score_reg  <= s_new_score;
            new_level_reg  <= s_new_level;
            idx_ok_reg     <= (32'(s_read_index) < ENTRIES);
            res_placed_reg <= 1'b0;
            res_rank_reg   <= '0;
            res_score_reg  <= '0;
            res_level_reg  <= '0;
        end else if (cmd.put_above || cmd.put_here) begin
            res_placed_reg <= 1'b1;
            res_rank_reg   <= tksi_pkg::rank_t'(waddr);
        end else if (cmd.capture_rd && idx_ok_reg) begin
            res_score_reg  <= ent_score;
            res_level_reg  <= ent_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_placed_reg <= res_placed_reg;
            m_rank_reg   <= res_rank_reg;
            m_score_reg  <= res_score_reg;
            m_level_reg  <= res_level_reg;
        end
    end

    assign m_placed      = m_placed_reg;
    assign m_rank        = m_rank_reg;
    assign m_entry_score = m_score_reg;
    assign m_entry_level = m_level_reg;

endmodule

// ===== sv/top_k_sorted_insert.sv =====
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Descending top-K table on a (score, level) key with insert and read words.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one request word: an insert (s_req_type 0) of
//   s_new_score/s_new_level, or a read (s_req_type 1) of s_read_index.
//   The m_ channel returns one word per request: m_placed/m_rank for an
//   insert, m_entry_score/m_entry_level for a read, other fields zero.
//   One request is handled at a time. A read looks up its entry and then
//   publishes it to the output register. An insert scans bottom-up, one
//   table position per cycle, and shifts lower entries on the way until
//   the record finds its place. The next word can be accepted once the
//   result moves into the output register.
//   The output register holds a finished word while m_ready is low; a
//   request accepted meanwhile is worked on, but its result waits for the
//   register to free, and s_ready stays low until it moves in.
//   Reset (aresetn low, synchronous) clears the per-entry valid bits, so the
//   table reads as all zeros at once, and empties the output register.
// ----------------------------------------------------------------------------
module top_k_sorted_insert #(
    parameter int ENTRIES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  tksi_pkg::score_t    s_new_score,
    input  tksi_pkg::level_t    s_new_level,
    input  tksi_pkg::idx_t      s_read_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_placed,
    output tksi_pkg::rank_t     m_rank,
    output tksi_pkg::score_t    m_entry_score,
    output tksi_pkg::level_t    m_entry_level
);

    tksi_pkg::cmd_t    cmd;
    tksi_pkg::status_t status;

    tksi_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .status     (status),
        .cmd        (cmd)
    );

    tksi_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_new_score   (s_new_score),
        .s_new_level   (s_new_level),
        .s_read_index  (s_read_index),
        .s_req_type    (s_req_type),
        .cmd           (cmd),
        .status        (status),
        .m_placed      (m_placed),
        .m_rank        (m_rank),
        .m_entry_score (m_entry_score),
        .m_entry_level (m_entry_level)
    );

`ifndef NO_ASSERTIONS
    // one word in flight: no accept in the cycle right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word accepted while previous one still in work");

    // a nonzero rank only comes with a placed record
    a_rank_needs_placed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_placed) |-> (m_rank == '0))
        else $error("rank reported without placement");

    // a placed insert result never carries entry data
    a_insert_no_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_placed) |-> (m_entry_score == '0 && m_entry_level == '0))
        else $error("placed result carries entry data");

    // the controller never requests a shift and a place, or two places, together
    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.shift_wr, cmd.put_above, cmd.put_here}) <= 1)
        else $error("more than one table write requested");
`endif

endmodule
